// ===== rtl/tls_client_hello_fingerprint_parser_top_macros.svh =====
// Assertion macros shared by the fingerprint parser RTL.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef TLS_CLIENT_HELLO_FINGERPRINT_PARSER_TOP_MACROS_SVH
`define TLS_CLIENT_HELLO_FINGERPRINT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TCFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcfp_pkg.sv =====
// Shared types, constants and helpers for the ClientHello fingerprint parser.
// No dependencies.
`timescale 1ns / 1ps

package tcfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned KIND_W  = 3;

    localparam logic [WORD_W-1:0] RANDOM_BYTES = 16'd32;

    // Extension types with a parsed body
    localparam logic [WORD_W-1:0] EXT_SUPPORTED_GROUPS = 16'h000a;
    localparam logic [WORD_W-1:0] EXT_POINT_FORMATS    = 16'h000b;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_VERSION = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CIPHER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXT     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GROUP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PF      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] value;
        logic              stream_end;
        logic              malformed;
    } tcfp_result_t;

    // GREASE: both bytes equal, low nibble 0xa (0x0a0a, 0x1a1a ... 0xfafa)
    function automatic logic is_grease(input logic [WORD_W-1:0] v);
        return (v[15:8] == v[7:0]) && (v[3:0] == 4'ha);
    endfunction

endpackage

// ===== rtl/tcfp_parser.sv =====
// Byte-serial ClientHello field walker: phase, counters and token decode.
// Depends on tcfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tls_client_hello_fingerprint_parser_top_macros.svh"

module tcfp_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [7:0]               msg_byte,
    input  logic                     msg_last,
    output tcfp_pkg::tcfp_result_t   result
);

    typedef enum logic [3:0] {
        PH_VER       = 4'd0,
        PH_RAND      = 4'd1,
        PH_SID_LEN   = 4'd2,
        PH_SID_SKIP  = 4'd3,
        PH_CS_LEN    = 4'd4,
        PH_CS_LIST   = 4'd5,
        PH_COMP_LEN  = 4'd6,
        PH_COMP_SKIP = 4'd7,
        PH_EXTS_LEN  = 4'd8,
        PH_EXT_TYPE  = 4'd9,
        PH_EXT_SIZE  = 4'd10,
        PH_GRP_LEN   = 4'd11,
        PH_GRP_LIST  = 4'd12,
        PH_PF_LEN    = 4'd13,
        PH_PF_LIST   = 4'd14,
        PH_SKIP_BODY = 4'd15
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic         half_sel_reg, half_sel_next;
    logic [7:0]   high_byte_reg, high_byte_next;
    logic [15:0]  skip_left_reg, skip_left_next;
    logic [15:0]  ext_type_reg, ext_type_next;
    logic [15:0]  ext_left_reg, ext_left_next;
    logic [15:0]  sub_left_reg, sub_left_next;

    logic [15:0]  pair_word;
    logic         in_ext_body;
    logic         have;
    logic         end_ok;
    logic [2:0]   kind;
    logic [15:0]  value;

    assign pair_word   = {high_byte_reg, msg_byte};
    assign in_ext_body = (phase_reg >= PH_GRP_LEN);

    always_comb begin
        phase_next     = phase_reg;
        half_sel_next  = half_sel_reg;
        high_byte_next = high_byte_reg;
        skip_left_next = skip_left_reg;
        ext_type_next  = ext_type_reg;
        ext_left_next  = ext_left_reg;
        sub_left_next  = sub_left_reg;
        have           = 1'b0;
        kind           = tcfp_pkg::KIND_END;
        value          = '0;
        end_ok         = 1'b0;

        // every byte inside an extension body counts against its size
        if (in_ext_body && ext_left_reg != 16'd0) begin
            ext_left_next = ext_left_reg - 16'd1;
        end

        case (phase_reg)
            PH_VER: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next  = 1'b0;
                    have           = 1'b1;
                    kind           = tcfp_pkg::KIND_VERSION;
                    value          = pair_word;
                    skip_left_next = tcfp_pkg::RANDOM_BYTES;
                    phase_next     = PH_RAND;
                end
            end
            PH_RAND, PH_SID_SKIP, PH_COMP_SKIP: begin
                if (skip_left_reg != 16'd0) begin
                    skip_left_next = skip_left_reg - 16'd1;
                end
                if (skip_left_next == 16'd0) begin
                    case (phase_reg)
                        PH_RAND:     phase_next = PH_SID_LEN;
                        PH_SID_SKIP: phase_next = PH_CS_LEN;
                        default:     phase_next = PH_EXTS_LEN;
                    endcase
                end
            end
            PH_SID_LEN: begin
                skip_left_next = {8'd0, msg_byte};
                phase_next     = (msg_byte != 8'd0) ? PH_SID_SKIP : PH_CS_LEN;
            end
            PH_CS_LEN: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next  = 1'b0;
                    skip_left_next = pair_word;
                    phase_next     = (pair_word != 16'd0) ? PH_CS_LIST : PH_COMP_LEN;
                end
            end
            PH_CS_LIST: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next = 1'b0;
                    if (!tcfp_pkg::is_grease(pair_word)) begin
                        have  = 1'b1;
                        kind  = tcfp_pkg::KIND_CIPHER;
                        value = pair_word;
                    end
                end
                if (skip_left_reg != 16'd0) begin
                    skip_left_next = skip_left_reg - 16'd1;
                end
                // a lone trailing byte of an odd list is dropped
                if (skip_left_next == 16'd0) begin
                    half_sel_next = 1'b0;
                    phase_next    = PH_COMP_LEN;
                end
            end
            PH_COMP_LEN: begin
                skip_left_next = {8'd0, msg_byte};
                phase_next     = (msg_byte != 8'd0) ? PH_COMP_SKIP : PH_EXTS_LEN;
            end
            PH_EXTS_LEN: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next = 1'b0;
                    phase_next    = PH_EXT_TYPE;
                end
            end
            PH_EXT_TYPE: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next = 1'b0;
                    ext_type_next = pair_word;
                    phase_next    = PH_EXT_SIZE;
                    if (!tcfp_pkg::is_grease(pair_word)) begin
                        have  = 1'b1;
                        kind  = tcfp_pkg::KIND_EXT;
                        value = pair_word;
                    end
                end
            end
            PH_EXT_SIZE: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next = 1'b0;
                    ext_left_next = pair_word;
                    if (pair_word == 16'd0) begin
                        phase_next = PH_EXT_TYPE;
                    end else if (ext_type_reg == tcfp_pkg::EXT_SUPPORTED_GROUPS) begin
                        phase_next = PH_GRP_LEN;
                    end else if (ext_type_reg == tcfp_pkg::EXT_POINT_FORMATS) begin
                        phase_next = PH_PF_LEN;
                    end else begin
                        phase_next = PH_SKIP_BODY;
                    end
                end
            end
            PH_GRP_LEN: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next = 1'b0;
                    sub_left_next = pair_word;
                    phase_next    = (pair_word != 16'd0) ? PH_GRP_LIST : PH_SKIP_BODY;
                end
            end
            PH_GRP_LIST: begin
                if (!half_sel_reg) begin
                    high_byte_next = msg_byte;
                    half_sel_next  = 1'b1;
                end else begin
                    half_sel_next = 1'b0;
                    if (!tcfp_pkg::is_grease(pair_word)) begin
                        have  = 1'b1;
                        kind  = tcfp_pkg::KIND_GROUP;
                        value = pair_word;
                    end
                end
                if (sub_left_reg != 16'd0) begin
                    sub_left_next = sub_left_reg - 16'd1;
                end
                if (sub_left_next == 16'd0) begin
                    half_sel_next = 1'b0;
                    phase_next    = PH_SKIP_BODY;
                end
            end
            PH_PF_LEN: begin
                sub_left_next = {8'd0, msg_byte};
                phase_next    = (msg_byte != 8'd0) ? PH_PF_LIST : PH_SKIP_BODY;
            end
            PH_PF_LIST: begin
                // point formats are never filtered
                have  = 1'b1;
                kind  = tcfp_pkg::KIND_PF;
                value = {8'd0, msg_byte};
                if (sub_left_reg != 16'd0) begin
                    sub_left_next = sub_left_reg - 16'd1;
                end
                if (sub_left_next == 16'd0) begin
                    phase_next = PH_SKIP_BODY;
                end
            end
            default: begin
            end
        endcase

        // extension size governs: a sublist is cut at the extension end
        if (in_ext_body && ext_left_next == 16'd0) begin
            half_sel_next = 1'b0;
            phase_next    = PH_EXT_TYPE;
        end

        if (msg_last) begin
            end_ok = (phase_next == PH_EXT_TYPE || phase_next == PH_EXTS_LEN)
                     && !half_sel_next;
            phase_next     = PH_VER;
            half_sel_next  = 1'b0;
            skip_left_next = '0;
            ext_type_next  = '0;
            ext_left_next  = '0;
            sub_left_next  = '0;
        end
    end

    assign result.valid      = have || msg_last;
    assign result.kind       = kind;
    assign result.value      = value;
    assign result.stream_end = msg_last;
    assign result.malformed  = msg_last && !end_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_VER;
            half_sel_reg  <= 1'b0;
            skip_left_reg <= '0;
            ext_type_reg  <= '0;
            ext_left_reg  <= '0;
            sub_left_reg  <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            half_sel_reg  <= half_sel_next;
            skip_left_reg <= skip_left_next;
            ext_type_reg  <= ext_type_next;
            ext_left_reg  <= ext_left_next;
            sub_left_reg  <= sub_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            high_byte_reg <= high_byte_next;
        end
    end

    `TCFP_ASSERT_NEXT(a_last_restarts, accept && msg_last, phase_reg == PH_VER && !half_sel_reg, "parser did not restart after final byte")
    `TCFP_ASSERT_NOW(a_body_has_size, in_ext_body, ext_left_reg != 16'd0, "extension body phase with no bytes left")

endmodule

// ===== rtl/tls_client_hello_fingerprint_parser_top.sv =====
// Channel | Dir | Bits (low to high)
// s_      | in  | tdata: msg_byte[7:0]; tlast: msg_last
// m_      | out | tdata: token_kind[2:0], token_value[18:3], zero[23:19];
//         |     | tlast: stream_end; tuser: malformed
// One byte per cycle while s_tready is high; a token is registered and appears on m_ in
// the cycle after its final byte. Rate is set by the parser phase/counter update.
// aresetn is synchronous, active low; it returns the parser to the version field.
// s_tready drops only while a result is held and m_tready is low.
`timescale 1ns / 1ps
`include "tls_client_hello_fingerprint_parser_top_macros.svh"

module tls_client_hello_fingerprint_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // msg_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // token_kind[2:0], token_value[18:3], zero[23:19]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // malformed[0]
);

    tcfp_pkg::tcfp_result_t result;
    logic                   accept;
    logic                   m_valid_reg;
    logic [2:0]             kind_reg;
    logic [15:0]            value_reg;
    logic                   end_reg;
    logic                   malformed_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tcfp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .msg_byte (s_tdata),
        .msg_last (s_tlast),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= accept && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            kind_reg      <= result.kind;
            value_reg     <= result.value;
            end_reg       <= result.stream_end;
            malformed_reg <= result.malformed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, value_reg, kind_reg};
    assign m_tlast  = end_reg;
    assign m_tuser  = malformed_reg;

    `TCFP_ASSERT_NEXT(a_last_gives_item, accept && s_tlast, m_tvalid && m_tlast, "final byte gave no end item")
    `TCFP_ASSERT_NOW(a_malformed_at_end, m_tvalid && m_tuser[0], m_tlast, "malformed flag away from end item")
    `TCFP_ASSERT_NOW(a_end_kind_at_end, m_tvalid && kind_reg == tcfp_pkg::KIND_END, m_tlast && value_reg == 16'd0, "end-only item not at stream end")
    `TCFP_ASSERT_NOW(a_kind_range, m_tvalid, kind_reg != 3'd6 && kind_reg != 3'd7, "token kind out of range")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the ClientHello fingerprint token parser.
// Uses tcfp_pkg for token kinds and extension codes; drives the top over its byte stream.
`timescale 1ns / 1ps

module tb_top;

    localparam int RAND_TARGET = 1300;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_MAX   = 5000;

    // Shadow parser that turns accepted bytes into expected tokens
    class hello_token_board;
        typedef enum logic [3:0] {
            P_VER, P_RAND, P_SID_LEN, P_SID_SKIP, P_CS_LEN, P_CS_LIST, P_COMP_LEN,
            P_COMP_SKIP, P_EXTS_LEN, P_EXT_TYPE, P_EXT_SIZE, P_GRP_LEN, P_GRP_LIST,
            P_PF_LEN, P_PF_LIST, P_SKIP_BODY
        } phase_e;

        typedef struct packed {
            logic [tcfp_pkg::KIND_W-1:0] kind;
            logic [tcfp_pkg::WORD_W-1:0] value;
            logic                        fin;
            logic                        bad;
        } token_t;

        token_t      pending_tokens[$];
        phase_e      phase;
        logic [15:0] cnt, ext_type, ext_left, sub_left;
        logic [7:0]  hi;
        bit          half, err;
        int          errors, checked, bad_ends;

        function new();
            errors = 0;
            checked = 0;
            bad_ends = 0;
            err = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase = P_VER;
            cnt = 0;
            hi = 0;
            ext_type = 0;
            ext_left = 0;
            sub_left = 0;
            half = 0;
        endfunction

        function bit greasy(logic [15:0] v);
            return (v[15:8] == v[7:0]) && (v[3:0] == 4'ha);
        endfunction

        // Big-endian 16-bit field assembly; 1 once the low byte is in
        function bit take_pair(logic [7:0] b, output logic [15:0] w);
            w = {hi, b};
            if (!half) begin
                hi = b;
                half = 1;
                return 0;
            end
            half = 0;
            return 1;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            token_t      t;
            logic [15:0] w;
            bit          have;
            phase_e      ph;
            t.kind = tcfp_pkg::KIND_END;
            t.value = 0;
            t.fin = 0;
            t.bad = 0;
            have = 0;
            ph = phase;

            // extension body bytes are counted in every body phase
            if (ph >= P_GRP_LEN && ext_left != 0) ext_left--;

            case (ph)
                P_VER: if (take_pair(b, w)) begin
                    t.kind = tcfp_pkg::KIND_VERSION;
                    t.value = w;
                    have = 1;
                    cnt = tcfp_pkg::RANDOM_BYTES;
                    phase = (cnt != 0) ? P_RAND : P_SID_LEN;
                end
                P_RAND, P_SID_SKIP: begin
                    if (cnt != 0) cnt--;
                    if (cnt == 0) phase = (ph == P_RAND) ? P_SID_LEN : P_CS_LEN;
                end
                P_SID_LEN: begin
                    cnt = {8'h00, b};
                    phase = (b != 0) ? P_SID_SKIP : P_CS_LEN;
                end
                P_CS_LEN: if (take_pair(b, w)) begin
                    cnt = w;
                    phase = (w != 0) ? P_CS_LIST : P_COMP_LEN;
                end
                P_CS_LIST: begin
                    if (take_pair(b, w) && !greasy(w)) begin
                        t.kind = tcfp_pkg::KIND_CIPHER;
                        t.value = w;
                        have = 1;
                    end
                    if (cnt != 0) cnt--;
                    if (cnt == 0) begin
                        half = 0;
                        phase = P_COMP_LEN;
                    end
                end
                P_COMP_LEN: begin
                    cnt = {8'h00, b};
                    phase = (b != 0) ? P_COMP_SKIP : P_EXTS_LEN;
                end
                P_COMP_SKIP: begin
                    if (cnt != 0) cnt--;
                    if (cnt == 0) phase = P_EXTS_LEN;
                end
                P_EXTS_LEN: if (take_pair(b, w)) phase = P_EXT_TYPE;
                P_EXT_TYPE: if (take_pair(b, w)) begin
                    ext_type = w;
                    if (!greasy(w)) begin
                        t.kind = tcfp_pkg::KIND_EXT;
                        t.value = w;
                        have = 1;
                    end
                    phase = P_EXT_SIZE;
                end
                P_EXT_SIZE: if (take_pair(b, w)) begin
                    ext_left = w;
                    if (w == 0) phase = P_EXT_TYPE;
                    else if (ext_type == tcfp_pkg::EXT_SUPPORTED_GROUPS) phase = P_GRP_LEN;
                    else if (ext_type == tcfp_pkg::EXT_POINT_FORMATS) phase = P_PF_LEN;
                    else phase = P_SKIP_BODY;
                end
                P_GRP_LEN: if (take_pair(b, w)) begin
                    sub_left = w;
                    phase = (w != 0) ? P_GRP_LIST : P_SKIP_BODY;
                end
                P_GRP_LIST: begin
                    if (take_pair(b, w) && !greasy(w)) begin
                        t.kind = tcfp_pkg::KIND_GROUP;
                        t.value = w;
                        have = 1;
                    end
                    if (sub_left != 0) sub_left--;
                    if (sub_left == 0) begin
                        half = 0;
                        phase = P_SKIP_BODY;
                    end
                end
                P_PF_LEN: begin
                    sub_left = {8'h00, b};
                    phase = (b != 0) ? P_PF_LIST : P_SKIP_BODY;
                end
                P_PF_LIST: begin
                    // point formats are never filtered
                    t.kind = tcfp_pkg::KIND_PF;
                    t.value = {8'h00, b};
                    have = 1;
                    if (sub_left != 0) sub_left--;
                    if (sub_left == 0) phase = P_SKIP_BODY;
                end
                default: ;
            endcase

            // extension size wins over any inner list length
            if (ph >= P_GRP_LEN && ext_left == 0) begin
                half = 0;
                phase = P_EXT_TYPE;
            end

            if (last) begin
                err = !((phase == P_EXT_TYPE || phase == P_EXTS_LEN) && !half);
                t.fin = 1;
                t.bad = err;
                if (err) bad_ends++;
                clear_parse();
                pending_tokens.push_back(t);
            end else if (have) begin
                pending_tokens.push_back(t);
            end
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t: token %0d %s mismatch: expected %h, got %h",
                     $time, checked, what, want, got);
        endfunction

        function void check_token(logic [23:0] data, logic fin, logic bad);
            token_t t;
            if (pending_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token: expected none, got data=%h last=%b user=%b",
                         $time, data, fin, bad);
                return;
            end
            t = pending_tokens.pop_front();
            if (data[2:0] !== t.kind) report("kind", 16'(t.kind), 16'(data[2:0]));
            if (data[18:3] !== t.value) report("value", t.value, data[18:3]);
            if (data[23:19] !== 5'd0) report("pad", 16'h0, 16'(data[23:19]));
            if (fin !== t.fin) report("stream_end", 16'(t.fin), 16'(fin));
            if (bad !== t.bad) report("malformed", 16'(t.bad), 16'(bad));
            checked++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    hello_token_board sb = new();

    logic [7:0] msg[$];
    bit         no_idle = 0;
    bit         hold_long = 0;
    int         bytes_sent = 0;
    int         msgs_sent = 0;

    tls_client_hello_fingerprint_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("[tls_client_hello_fingerprint_parser_top] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly random, with GREASE and all-zero / all-one words mixed in
    function automatic logic [15:0] rand_word();
        logic [3:0] g;
        g = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0: return {g, 4'ha, g, 4'ha};
            1: return 16'h0000;
            2: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic put8(input logic [7:0] b);
        msg.push_back(b);
    endtask

    task automatic put16(input logic [15:0] w);
        msg.push_back(w[15:8]);
        msg.push_back(w[7:0]);
    endtask

    // Called at a rising edge; returns at the edge that accepts the item
    task automatic drive_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_msg();
        int i;
        for (i = 0; i < msg.size(); i++) drive_byte(msg[i], i == msg.size() - 1);
        msg.delete();
        msgs_sent++;
    endtask

    // One extension: mostly consistent sizes, sometimes padded or cut short
    task automatic put_ext();
        logic [7:0]  body[$];
        logic [15:0] etype;
        int          n, sz, i;
        n = $urandom_range(0, 4);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                etype = tcfp_pkg::EXT_SUPPORTED_GROUPS;
                sz = 2 * n + (($urandom_range(0, 7) == 0) ? 1 : 0);
                body.push_back(8'(sz >> 8));
                body.push_back(8'(sz));
                repeat (n) begin
                    etype = rand_word();
                    body.push_back(etype[15:8]);
                    body.push_back(etype[7:0]);
                end
                etype = tcfp_pkg::EXT_SUPPORTED_GROUPS;
                if (sz[0]) body.push_back(8'($urandom));
            end
            3, 4, 5: begin
                etype = tcfp_pkg::EXT_POINT_FORMATS;
                body.push_back(8'(n));
                repeat (n) body.push_back(8'($urandom));
            end
            6: begin
                etype[7:0]  = {4'($urandom_range(0, 15)), 4'ha};
                etype[15:8] = etype[7:0];
                repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
            end
            7: etype = 16'h0000;
            default: begin
                etype = 16'($urandom);
                repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
            end
        endcase
        sz = body.size();
        case ($urandom_range(0, 7))
            6: sz = sz + $urandom_range(1, 3);
            7: sz = (sz > 0) ? $urandom_range(0, sz - 1) : 0;
            default: ;
        endcase
        put16(etype);
        put16(16'(sz));
        for (i = 0; i < sz; i++) put8((i < body.size()) ? body[i] : 8'($urandom));
    endtask

    task automatic build_hello();
        int          n, pos, odd;
        logic [15:0] tot;
        put16(rand_word());
        repeat (tcfp_pkg::RANDOM_BYTES) put8(8'($urandom));
        case ($urandom_range(0, 19))
            0: n = 255;
            1, 2: n = 32;
            default: n = $urandom_range(0, 4);
        endcase
        put8(8'(n));
        repeat (n) put8(8'($urandom));
        n = $urandom_range(0, 6);
        odd = ($urandom_range(0, 7) == 0) ? 1 : 0;
        put16(16'(2 * n + odd));
        repeat (n) put16(rand_word());
        if (odd) put8(8'($urandom));
        n = $urandom_range(0, 2);
        put8(8'(n));
        repeat (n) put8(8'($urandom));
        if ($urandom_range(0, 7) == 0) return;  // no extension block
        pos = msg.size();
        put16(16'h0000);
        repeat ($urandom_range(0, 5)) put_ext();
        tot = 16'(msg.size() - pos - 2);
        msg[pos] = tot[15:8];
        msg[pos + 1] = tot[7:0];
    endtask

    // Receiver: random back-pressure plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_token(m_tdata, m_tlast, m_tuser[0]);
            if (stall_left == 0 && hold_long) begin
                hold_long = 0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    initial begin
        int start, n_rand, cut, drain, sel;
        s_tvalid <= 0;
        s_tdata  <= 0;
        s_tlast  <= 0;
        aresetn  <= 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Odd cipher list with GREASE, GREASE extension of size zero, group list with
        // trailing body bytes, point-format list cut by its extension, end between extensions
        put16(16'h0303);
        repeat (tcfp_pkg::RANDOM_BYTES) put8(8'hff);
        put8(8'h00);
        put16(16'd7);
        put16(16'h0a0a);
        put16(16'hc02f);
        put16(16'hffff);
        put8(8'h13);
        put8(8'h01);
        put8(8'h00);
        put16(16'h0020);
        put16(16'hfafa);
        put16(16'h0000);
        put16(tcfp_pkg::EXT_SUPPORTED_GROUPS);
        put16(16'd8);
        put16(16'd4);
        put16(16'h1a1a);
        put16(16'h001d);
        put16(16'hbeef);
        put16(tcfp_pkg::EXT_POINT_FORMATS);
        put16(16'd2);
        put8(8'd3);
        put8(8'h0a);
        put16(16'h0000);
        put16(16'h0000);
        send_msg();

        // Full session id, empty cipher list, ends right after compression list
        put16(16'h0000);
        repeat (tcfp_pkg::RANDOM_BYTES) put8(8'h00);
        put8(8'd32);
        repeat (32) put8(8'haa);
        put16(16'h0000);
        put8(8'h00);
        send_msg();

        // Ends inside the random, then a lone version byte
        put16(16'hffff);
        repeat (10) put8(8'($urandom));
        send_msg();
        put8(8'h03);
        send_msg();

        // Empty group list, group list cut by size, empty point formats, ends on a token
        put16(16'h0301);
        repeat (tcfp_pkg::RANDOM_BYTES) put8(8'($urandom));
        put8(8'h01);
        put8(8'h55);
        put16(16'd2);
        put16(16'h00ff);
        put8(8'h00);
        put16(16'hffff);
        put16(tcfp_pkg::EXT_SUPPORTED_GROUPS);
        put16(16'd2);
        put16(16'd0);
        put16(tcfp_pkg::EXT_SUPPORTED_GROUPS);
        put16(16'd4);
        put16(16'd6);
        put16(16'h0017);
        put16(tcfp_pkg::EXT_POINT_FORMATS);
        put16(16'd1);
        put8(8'd0);
        put16(tcfp_pkg::EXT_POINT_FORMATS);
        put16(16'd3);
        put8(8'd2);
        put8(8'h00);
        put8(8'hff);
        send_msg();

        start = bytes_sent;
        n_rand = 0;
        while (bytes_sent - start < RAND_TARGET) begin
            n_rand++;
            no_idle = ($urandom_range(0, 4) == 0);
            if (n_rand == 3) hold_long = 1;
            if (n_rand == 7) begin
                s_tvalid <= 0;
                @(posedge aclk);
                while (sb.pending_tokens.size() != 0) @(posedge aclk);
            end
            sel = $urandom_range(0, 9);
            if (sel == 9) begin
                repeat ($urandom_range(1, 24)) put8(8'($urandom));
            end else begin
                build_hello();
                if (sel >= 7) begin
                    cut = $urandom_range(1, msg.size());
                    while (msg.size() > cut) void'(msg.pop_back());
                end
            end
            send_msg();
        end
        s_tvalid <= 0;

        drain = 0;
        while (sb.pending_tokens.size() != 0 && drain < DRAIN_MAX) begin
            @(posedge aclk);
            drain++;
        end
        repeat (8) @(posedge aclk);
        if (sb.pending_tokens.size() != 0) begin
            sb.errors += sb.pending_tokens.size();
            $display("%0t: %0d expected tokens never arrived", $time, sb.pending_tokens.size());
        end

        $display("Sent %0d bytes in %0d messages (%0d ended malformed); %0d tokens checked.",
                 bytes_sent, msgs_sent, sb.bad_ends, sb.checked);
        if (sb.errors == 0) begin
            $display("[tls_client_hello_fingerprint_parser_top] OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("[tls_client_hello_fingerprint_parser_top] ERROR");
        end
        $finish;
    end

endmodule
